FILE: design/dcp_pkg.sv
// Shared types and register codes for the dipole corrector particle map.
`default_nettype none
package dcp_pkg;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_LENGTH = 3'd0,
        CFG_KICK_X      = 3'd1,
        CFG_KICK_Y      = 3'd2,
        CFG_APERTURE_X  = 3'd3,
        CFG_APERTURE_Y  = 3'd4,
        CFG_INV_BETA0   = 3'd5
    } dcp_cfg_idx_t;

    // side information that travels with each quotient through the divider
    typedef struct packed {
        logic neg;
        logic bzero;
        logic azero;
        logic ovf;
    } dcp_div_flags_t;

endpackage
`default_nettype wire

FILE: design/dcp_delay.sv
// Enabled shift-register delay line for aligning pipeline operands.
`default_nettype none
module dcp_delay
    import dcp_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1
)
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] din,
    output logic      [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] sr_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                sr_reg[i] <= sr_reg[i-1];
            end
        end
    end

    assign dout = sr_reg[DEPTH-1];

endmodule
`default_nettype wire

FILE: design/dcp_sqrt.sv
// Pipelined integer square root, one result bit per stage, floor rounding.
`default_nettype none
module dcp_sqrt
    import dcp_pkg::*;
#(
    parameter int SQW = 29
)
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [2*SQW-1:0] rad,
    output logic      [SQW-1:0]   root
);

    logic [SQW:0]     rem_reg  [SQW];
    logic [SQW-1:0]   root_reg [SQW];
    logic [2*SQW-1:0] rad_reg  [SQW];

    for (genvar i = 0; i < SQW; i++)
    begin : g_stage
        logic [SQW:0]     rem_p;
        logic [SQW-1:0]   root_p;
        logic [2*SQW-1:0] rad_p;
        logic [SQW+2:0]   rem_t;
        logic [SQW+2:0]   trial;
        logic             ge;

        if (i == 0)
        begin : g_first
            assign rem_p  = '0;
            assign root_p = '0;
            assign rad_p  = rad;
        end
        else
        begin : g_next
            assign rem_p  = rem_reg[i-1];
            assign root_p = root_reg[i-1];
            assign rad_p  = rad_reg[i-1];
        end

        assign rem_t = {rem_p, rad_p[2*SQW-1:2*SQW-2]};
        assign trial = {1'b0, root_p, 2'b01};
        assign ge    = (rem_t >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? (SQW+1)'(rem_t - trial) : (SQW+1)'(rem_t);
                root_reg[i] <= {root_p[SQW-2:0], ge};
                rad_reg[i]  <= {rad_p[2*SQW-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[SQW-1];

endmodule
`default_nettype wire

FILE: design/dcp_div.sv
// Pipelined saturating fixed-point divider: (a << F) / b, truncated toward zero.
`default_nettype none
module dcp_div
    import dcp_pkg::*;
#(
    parameter int W  = 32,
    parameter int F  = 24,
    parameter int DW = 29
)
(
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic signed [W-1:0] num,
    input  wire logic        [DW-1:0] den,
    output logic signed      [W-1:0] quo
);

    localparam int QW = W + 1;
    localparam int NW = W + F;
    localparam int CW = (F - 1 > DW) ? F - 1 : DW;

    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [QW-1:0] QMAX  = {2'b00, {(W-1){1'b1}}};
    localparam logic [QW-1:0] QHALF = {2'b01, {(W-1){1'b0}}};

    // prep stage
    logic           neg;
    logic [W-1:0]   mag;
    logic [NW-1:0]  nfull;
    logic [F-2:0]   hi;
    dcp_div_flags_t flg_p;

    assign neg   = num[W-1];
    assign mag   = neg ? (~num + 1'b1) : num;
    assign nfull = {mag, {F{1'b0}}};
    assign hi    = nfull[NW-1:QW];

    always_comb
    begin
        flg_p.neg   = neg;
        flg_p.bzero = (den == '0);
        flg_p.azero = (num == '0);
        // quotient would need more than QW bits
        flg_p.ovf   = (den != '0) && (CW'(hi) >= CW'(den));
    end

    logic [DW-1:0]  rem_reg [QW+1];
    logic [QW-1:0]  lo_reg  [QW+1];
    logic [QW-1:0]  q_reg   [QW+1];
    logic [DW-1:0]  den_reg [QW+1];
    dcp_div_flags_t flg_reg [QW+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DW'(hi);
            lo_reg[0]  <= nfull[QW-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den;
            flg_reg[0] <= flg_p;
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [DW:0] rem_t;
        logic        ge;

        assign rem_t = {rem_reg[k], lo_reg[k][QW-1]};
        assign ge    = (rem_t >= {1'b0, den_reg[k]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= ge ? DW'(rem_t - {1'b0, den_reg[k]}) : DW'(rem_t);
                lo_reg[k+1]  <= {lo_reg[k][QW-2:0], 1'b0};
                q_reg[k+1]   <= {q_reg[k][QW-2:0], ge};
                den_reg[k+1] <= den_reg[k];
                flg_reg[k+1] <= flg_reg[k];
            end
        end
    end

    logic [QW-1:0]       q;
    dcp_div_flags_t      f;
    logic signed [W-1:0] quo_next;
    logic signed [W-1:0] quo_reg;

    assign q = q_reg[QW];
    assign f = flg_reg[QW];

    always_comb
    begin
        if (f.bzero)
        begin
            quo_next = f.azero ? '0 : (f.neg ? VMIN : VMAX);
        end
        else if (f.neg)
        begin
            quo_next = (f.ovf || q > QHALF) ? VMIN : W'(~q + 1'b1);
        end
        else
        begin
            quo_next = (f.ovf || q > QMAX) ? VMAX : q[W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule
`default_nettype wire

FILE: design/dipole_corrector_particle_map_unit.sv
// Top level: corrector-magnet particle map, deep pipeline, one particle per cycle unless the output is held.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid/in_ready, coordinates, flags     | to block
//  out     | out_valid/out_ready, coordinates, flags   | from block
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | to block
//
// One particle enters per cycle while the output is not held. The latency is
// set by the square root pipe and three chained pipelined dividers (d1 enters
// the longitudinal term cubed).
// Reset clears the valid bits and sets the configuration registers (inverse beta0 to one); no clearing pass.
// When the output is held, the whole pipe freezes; nothing is lost or repeated.
// Configuration writes are accepted every cycle.
`default_nettype none
module dipole_corrector_particle_map_unit
    import dcp_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 24
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] x_pos,
    input  wire logic signed [COORD_WIDTH-1:0] x_slope,
    input  wire logic signed [COORD_WIDTH-1:0] y_pos,
    input  wire logic signed [COORD_WIDTH-1:0] y_slope,
    input  wire logic signed [COORD_WIDTH-1:0] time_lag,
    input  wire logic signed [COORD_WIDTH-1:0] momentum_dev,
    input  wire logic        [COORD_WIDTH-2:0] path_length,
    input  wire logic                          alive_in,
    input  wire logic                          last_in,

    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed      [COORD_WIDTH-1:0] x_pos_out,
    output logic signed      [COORD_WIDTH-1:0] x_slope_out,
    output logic signed      [COORD_WIDTH-1:0] y_pos_out,
    output logic signed      [COORD_WIDTH-1:0] y_slope_out,
    output logic signed      [COORD_WIDTH-1:0] time_lag_out,
    output logic             [COORD_WIDTH-2:0] path_length_out,
    output logic                               alive_out,
    output logic                               last_out,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic        [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic        [COORD_WIDTH-1:0] cfg_data
);

    localparam int W   = COORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int WX  = W + 4;
    localparam int SQW = (W + 2 + F + 1) / 2;
    localparam int LS  = SQW;
    localparam int LD  = W + 3;

    localparam int D_SQ  = 3 + LS;
    localparam int D_V1  = D_SQ + LD;
    localparam int D_V2  = D_V1 + LD;
    localparam int D_V3  = D_V2 + LD;
    localparam int D_F   = D_V3 + 1;
    localparam int D_OUT = D_F + 6;
    localparam int IBW   = 6 * W + 1;

    localparam logic signed [W-1:0]   VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]   VMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [2*W-1:0] PMAX = {{(W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [2*W-1:0] PMIN = ~PMAX;
    localparam logic signed [WX-1:0]  SMAX = {5'b00000, {(W-1){1'b1}}};
    localparam logic signed [WX-1:0]  SMIN = ~SMAX;
    localparam logic signed [WX-1:0]  ONE_X = {{(WX-1){1'b0}}, 1'b1} << F;
    localparam logic [W-2:0]          ONE_U = {{(W-2){1'b0}}, 1'b1} << F;

    // floor(2^(W+1) / 3), built by long division at elaboration
    function automatic logic [W-1:0] recip3();
        logic [1:0]   r;
        logic [2:0]   t;
        logic [W+1:0] m;
        r = 2'd0;
        m = '0;
        for (int k = W + 1; k >= 0; k--)
        begin
            t = {r, (k == W + 1)};
            if (t >= 3'd3)
            begin
                r    = 2'(t - 3'd3);
                m[k] = 1'b1;
            end
            else
            begin
                r = t[1:0];
            end
        end
        return m[W-1:0];
    endfunction

    localparam logic [W-1:0] M3 = recip3();

    function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic signed [2*W-1:0] p;
        logic signed [2*W-1:0] s;
        p = (2*W)'(a) * (2*W)'(b);
        s = p >>> F;
        if (s > PMAX)
            return VMAX;
        else if (s < PMIN)
            return VMIN;
        return s[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat_x(input logic signed [WX-1:0] v);
        if (v > SMAX)
            return VMAX;
        else if (v < SMIN)
            return VMIN;
        return v[W-1:0];
    endfunction

    // halve, truncating toward zero
    function automatic logic signed [W-1:0] half_tz(input logic signed [W-1:0] v);
        logic signed [W:0] t;
        t = (W+1)'(v) + $signed({{W{1'b0}}, v[W-1]});
        return t[W:1];
    endfunction

    // ---------------- configuration ----------------
    logic        [W-2:0] step_length_reg;
    logic signed [W-1:0] kick_x_reg;
    logic signed [W-1:0] kick_y_reg;
    logic        [W-2:0] aperture_x_reg;
    logic        [W-2:0] aperture_y_reg;
    logic        [W-2:0] inv_beta0_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_length_reg <= '0;
            kick_x_reg      <= '0;
            kick_y_reg      <= '0;
            aperture_x_reg  <= '0;
            aperture_y_reg  <= '0;
            inv_beta0_reg   <= ONE_U;
        end
        else if (cfg_valid)
        begin
            unique case (dcp_cfg_idx_t'(cfg_index))
                CFG_STEP_LENGTH: step_length_reg <= cfg_data[W-2:0];
                CFG_KICK_X:      kick_x_reg      <= cfg_data;
                CFG_KICK_Y:      kick_y_reg      <= cfg_data;
                CFG_APERTURE_X:  aperture_x_reg  <= cfg_data[W-2:0];
                CFG_APERTURE_Y:  aperture_y_reg  <= cfg_data[W-2:0];
                CFG_INV_BETA0:   inv_beta0_reg   <= cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    logic signed [W-1:0] ds_s;
    logic signed [W-1:0] ib_s;

    assign ds_s = $signed({1'b0, step_length_reg});
    assign ib_s = $signed({1'b0, inv_beta0_reg});

    // registered products of configuration only; dsqky and dsqkx build on dsq_reg
    logic signed [W-1:0] dsq_reg;
    logic signed [W-1:0] dsky_reg;
    logic signed [W-1:0] dskx_reg;
    logic signed [W-1:0] dsib_reg;
    logic signed [W-1:0] kk_reg;
    logic signed [W-1:0] dsqky_reg;
    logic signed [W-1:0] dsqkx_reg;
    logic                ap_on_reg;

    always_ff @(posedge clk)
    begin
        dsq_reg   <= fmul(ds_s, ds_s);
        dsky_reg  <= fmul(ds_s, kick_y_reg);
        dskx_reg  <= fmul(ds_s, kick_x_reg);
        dsib_reg  <= fmul(ds_s, ib_s);
        kk_reg    <= sat_x(WX'(fmul(kick_x_reg, kick_x_reg))
                           + WX'(fmul(kick_y_reg, kick_y_reg)));
        dsqky_reg <= fmul(dsq_reg, kick_y_reg);
        dsqkx_reg <= fmul(dsq_reg, kick_x_reg);
        ap_on_reg <= (aperture_x_reg != '0) && (aperture_y_reg != '0);
    end

    // ---------------- pipeline control ----------------
    logic             adv;
    logic [D_OUT-1:0] vld_reg;

    assign adv       = !vld_reg[D_OUT-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[D_OUT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[D_OUT-2:0], in_valid};
        end
    end

    // ---------------- input stage ----------------
    logic signed [W-1:0] x0_reg;
    logic signed [W-1:0] px0_reg;
    logic signed [W-1:0] y0_reg;
    logic signed [W-1:0] py0_reg;
    logic signed [W-1:0] ct0_reg;
    logic signed [W-1:0] dp_reg;
    logic        [W-2:0] path_reg;
    logic                alive_reg;
    logic                last_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_reg    <= x_pos;
            px0_reg   <= x_slope;
            y0_reg    <= y_pos;
            py0_reg   <= y_slope;
            ct0_reg   <= time_lag;
            dp_reg    <= momentum_dev;
            path_reg  <= path_length;
            alive_reg <= alive_in;
            last_reg  <= last_in;
        end
    end

    // ---------------- stage A: products and sums ----------------
    logic signed [W-1:0] dpib_reg, dpdp_reg, dspx_reg, dspy_reg, e_reg;
    logic signed [W-1:0] kypx_reg, kxpy_reg, pxpx_reg, pypy_reg;
    logic signed [W-1:0] px1_reg, py1_reg;
    logic        [W-2:0] path1_reg;
    logic signed [W:0]   u_reg;
    logic        [W-1:0] path_sum;

    assign path_sum = {1'b0, path_reg} + {1'b0, step_length_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dpib_reg  <= fmul(dp_reg, ib_s);
            dpdp_reg  <= fmul(dp_reg, dp_reg);
            dspx_reg  <= fmul(ds_s, px0_reg);
            dspy_reg  <= fmul(ds_s, py0_reg);
            e_reg     <= sat_x(WX'(ib_s) + WX'(dp_reg));
            kypx_reg  <= fmul(kick_y_reg, px0_reg);
            kxpy_reg  <= fmul(kick_x_reg, py0_reg);
            pxpx_reg  <= fmul(px0_reg, px0_reg);
            pypy_reg  <= fmul(py0_reg, py0_reg);
            px1_reg   <= sat_x(WX'(px0_reg) - WX'(dsky_reg));
            py1_reg   <= sat_x(WX'(py0_reg) + WX'(dskx_reg));
            path1_reg <= path_sum[W-1] ? {(W-1){1'b1}} : path_sum[W-2:0];
            u_reg     <= (W+1)'(ct0_reg) + (W+1)'(dsib_reg);
        end
    end

    // ---------------- stage B: radicand, products and sums ----------------
    logic        [W+1:0] rad_reg;
    logic signed [W-1:0] dse_reg, kp_reg, pp_reg, dspx_b_reg, dspy_b_reg;
    logic signed [WX-1:0] rad_x;

    assign rad_x = ONE_X + (WX'(dpib_reg) <<< 1) + WX'(dpdp_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_reg    <= rad_x[WX-1] ? '0 : rad_x[W+1:0];
            dse_reg    <= fmul(ds_s, e_reg);
            kp_reg     <= sat_x(WX'(kypx_reg) - WX'(kxpy_reg));
            pp_reg     <= sat_x(WX'(pxpx_reg) + WX'(pypy_reg));
            dspx_b_reg <= dspx_reg;
            dspy_b_reg <= dspy_reg;
        end
    end

    // ---------------- d1 = sqrt(rad << F) ----------------
    logic [SQW-1:0] d1;

    dcp_sqrt #(.SQW(SQW)) u_sqrt (
        .clk  (clk),
        .en   (adv),
        .rad  ((2*SQW)'({rad_reg, {F{1'b0}}})),
        .root (d1)
    );

    logic [3*W-1:0] num_d;

    dcp_delay #(.WIDTH(3*W), .DEPTH(LS)) u_dly_num (
        .clk  (clk),
        .en   (adv),
        .din  ({dspx_b_reg, dspy_b_reg, dse_reg}),
        .dout (num_d)
    );

    logic [SQW-1:0] d1_v1, d1_v2;

    dcp_delay #(.WIDTH(SQW), .DEPTH(LD)) u_dly_d1a (
        .clk (clk), .en (adv), .din (d1), .dout (d1_v1)
    );

    dcp_delay #(.WIDTH(SQW), .DEPTH(LD)) u_dly_d1b (
        .clk (clk), .en (adv), .din (d1_v1), .dout (d1_v2)
    );

    // ---------------- division ranks (e2 and e3 chain on e1) ----------------
    logic signed [W-1:0] q_px, q_py, q_ky, q_kx, q_dse, q2, q3;

    dcp_div #(.W(W), .F(F), .DW(SQW)) u_div_px (
        .clk (clk), .en (adv), .num (num_d[3*W-1:2*W]), .den (d1), .quo (q_px)
    );

    dcp_div #(.W(W), .F(F), .DW(SQW)) u_div_py (
        .clk (clk), .en (adv), .num (num_d[2*W-1:W]), .den (d1), .quo (q_py)
    );

    dcp_div #(.W(W), .F(F), .DW(SQW)) u_div_ky (
        .clk (clk), .en (adv), .num (dsqky_reg), .den (d1), .quo (q_ky)
    );

    dcp_div #(.W(W), .F(F), .DW(SQW)) u_div_kx (
        .clk (clk), .en (adv), .num (dsqkx_reg), .den (d1), .quo (q_kx)
    );

    dcp_div #(.W(W), .F(F), .DW(SQW)) u_div_e1 (
        .clk (clk), .en (adv), .num (num_d[W-1:0]), .den (d1), .quo (q_dse)
    );

    dcp_div #(.W(W), .F(F), .DW(SQW)) u_div_e2 (
        .clk (clk), .en (adv), .num (q_dse), .den (d1_v1), .quo (q2)
    );

    dcp_div #(.W(W), .F(F), .DW(SQW)) u_div_e3 (
        .clk (clk), .en (adv), .num (q2), .den (d1_v2), .quo (q3)
    );

    // ---------------- transverse positions ----------------
    logic [2*W-1:0]      xy0_d;
    logic signed [W-1:0] x1_reg, y1_reg;

    dcp_delay #(.WIDTH(2*W), .DEPTH(D_V1-1)) u_dly_xy0 (
        .clk (clk), .en (adv), .din ({x0_reg, y0_reg}), .dout (xy0_d)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg <= sat_x(WX'($signed(xy0_d[2*W-1:W])) + WX'(q_px)
                            - WX'(half_tz(q_ky)));
            y1_reg <= sat_x(WX'($signed(xy0_d[W-1:0])) + WX'(q_py)
                            + WX'(half_tz(q_kx)));
        end
    end

    logic [2*W-1:0] xy1_d;

    dcp_delay #(.WIDTH(2*W), .DEPTH(D_OUT-2-D_V1)) u_dly_xy1 (
        .clk (clk), .en (adv), .din ({x1_reg, y1_reg}), .dout (xy1_d)
    );

    // ---------------- longitudinal term ----------------
    logic [2*W-1:0]      kppp_d;
    logic signed [W-1:0] qdse_d;
    logic [W:0]          u_d;

    dcp_delay #(.WIDTH(2*W), .DEPTH(D_F-3)) u_dly_kppp (
        .clk (clk), .en (adv), .din ({kp_reg, pp_reg}), .dout (kppp_d)
    );

    dcp_delay #(.WIDTH(W), .DEPTH(D_F+4-D_V1)) u_dly_qdse (
        .clk (clk), .en (adv), .din (q_dse), .dout (qdse_d)
    );

    dcp_delay #(.WIDTH(W+1), .DEPTH(D_F+2)) u_dly_u (
        .clk (clk), .en (adv), .din (u_reg), .dout (u_d)
    );

    logic signed [W-1:0]   f1_reg;
    logic signed [W-1:0]   a1_reg, a2_reg, a3_reg, kp_m1_reg;
    logic signed [W-1:0]   b1_reg, b2_reg, a3_m2_reg;
    logic        [2*W-1:0] prod_reg;
    logic        [W-1:0]   n_reg;
    logic                  neg3_reg;
    logic signed [W:0]     v3_reg, v4_reg, v5_reg;
    logic signed [W-1:0]   b1d3_reg;
    logic signed [W-1:0]   c0_reg;
    logic        [W-1:0]   n_abs;
    logic        [W-1:0]   q0;
    logic        [W+1:0]   t3;
    logic        [W+1:0]   r3;
    logic        [W-1:0]   q3c;

    assign n_abs = b1_reg[W-1] ? (~b1_reg + 1'b1) : b1_reg;
    assign q0    = W'(prod_reg[2*W-1:W+1]);
    assign t3    = {q0, 1'b0} + (W+2)'(q0);
    assign r3    = (W+2)'(n_reg) - t3;
    // reciprocal estimate is low by at most one
    assign q3c   = (r3 >= (W+2)'(3)) ? q0 + 1'b1 : q0;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_reg    <= half_tz(q3);
            a1_reg    <= fmul(dsq_reg, f1_reg);
            a2_reg    <= fmul(ds_s, f1_reg);
            a3_reg    <= fmul(f1_reg, $signed(kppp_d[W-1:0]));
            kp_m1_reg <= kppp_d[2*W-1:W];
            b1_reg    <= fmul(a1_reg, kk_reg);
            b2_reg    <= fmul(a2_reg, kp_m1_reg);
            a3_m2_reg <= a3_reg;
            prod_reg  <= (2*W)'(n_abs) * (2*W)'(M3);
            n_reg     <= n_abs;
            neg3_reg  <= b1_reg[W-1];
            v3_reg    <= (W+1)'(b2_reg) - (W+1)'(a3_m2_reg);
            b1d3_reg  <= neg3_reg ? (~q3c + 1'b1) : q3c;
            v4_reg    <= v3_reg;
            c0_reg    <= sat_x(WX'($signed(u_d)) - WX'(qdse_d) - WX'(b1d3_reg));
            v5_reg    <= v4_reg;
        end
    end

    // ---------------- aperture ----------------
    logic signed [W-1:0] rx, ry;
    logic signed [W-1:0] rxx_reg, ryy_reg;
    logic                lost_reg;
    logic [0:0]          lost_d;

    dcp_div #(.W(W), .F(F), .DW(W-1)) u_div_ax (
        .clk (clk), .en (adv), .num (x0_reg), .den (aperture_x_reg), .quo (rx)
    );

    dcp_div #(.W(W), .F(F), .DW(W-1)) u_div_ay (
        .clk (clk), .en (adv), .num (y0_reg), .den (aperture_y_reg), .quo (ry)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rxx_reg  <= fmul(rx, rx);
            ryy_reg  <= fmul(ry, ry);
            lost_reg <= ap_on_reg && ((WX'(rxx_reg) + WX'(ryy_reg)) > ONE_X);
        end
    end

    dcp_delay #(.WIDTH(1), .DEPTH(D_OUT-4-LD)) u_dly_lost (
        .clk (clk), .en (adv), .din (lost_reg), .dout (lost_d)
    );

    // ---------------- passthrough operands ----------------
    logic [IBW-1:0]   ib_d;
    logic [3*W-2:0]   pa_d;

    dcp_delay #(.WIDTH(IBW), .DEPTH(D_OUT-2)) u_dly_in (
        .clk  (clk),
        .en   (adv),
        .din  ({x0_reg, px0_reg, y0_reg, py0_reg, ct0_reg, path_reg,
                alive_reg, last_reg}),
        .dout (ib_d)
    );

    dcp_delay #(.WIDTH(3*W-1), .DEPTH(D_OUT-3)) u_dly_pa (
        .clk (clk), .en (adv), .din ({px1_reg, py1_reg, path1_reg}), .dout (pa_d)
    );

    // ---------------- output stage ----------------
    logic signed [W-1:0] x_out_reg, px_out_reg, y_out_reg, py_out_reg, ct_out_reg;
    logic        [W-2:0] path_out_reg;
    logic                alive_out_reg, last_out_reg;
    logic                alive_d;

    assign alive_d = ib_d[1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            last_out_reg <= ib_d[0];
            if (alive_d)
            begin
                x_out_reg     <= xy1_d[2*W-1:W];
                y_out_reg     <= xy1_d[W-1:0];
                px_out_reg    <= pa_d[3*W-2:2*W-1];
                py_out_reg    <= pa_d[2*W-2:W-1];
                path_out_reg  <= pa_d[W-2:0];
                ct_out_reg    <= sat_x(WX'(c0_reg) + WX'(v5_reg));
                alive_out_reg <= !lost_d[0];
            end
            else
            begin
                x_out_reg     <= ib_d[IBW-1:IBW-W];
                px_out_reg    <= ib_d[IBW-W-1:IBW-2*W];
                y_out_reg     <= ib_d[IBW-2*W-1:IBW-3*W];
                py_out_reg    <= ib_d[IBW-3*W-1:IBW-4*W];
                ct_out_reg    <= ib_d[IBW-4*W-1:IBW-5*W];
                path_out_reg  <= ib_d[W:2];
                alive_out_reg <= 1'b0;
            end
        end
    end

    assign x_pos_out       = x_out_reg;
    assign x_slope_out     = px_out_reg;
    assign y_pos_out       = y_out_reg;
    assign y_slope_out     = py_out_reg;
    assign time_lag_out    = ct_out_reg;
    assign path_length_out = path_out_reg;
    assign alive_out       = alive_out_reg;
    assign last_out        = last_out_reg;

endmodule
`default_nettype wire
